FILE: rtl/itv_pkg.sv
// shared types and constants for the iso timestamp validator
`timescale 1ns / 1ps
`default_nettype none

package itv_pkg;

  localparam int QueueDepth = 2;

  localparam int CharW  = 8;
  localparam int PosW   = 5;
  localparam int FieldW = 7;
  localparam int DigitW = 4;

  localparam logic [PosW-1:0] PosMax       = 5'd31;
  localparam logic [PosW-1:0] DateLastPos  = 5'd9;
  localparam logic [PosW-1:0] StampLastPos = 5'd23;

  typedef enum logic [2:0] {
    FLD_NONE,
    FLD_YEAR_HI,
    FLD_YEAR_LO,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND
  } itv_field_t;

  // one classified character, handed from the front end to the checker
  typedef struct packed {
    logic [DigitW-1:0] digit;
    itv_field_t        field;
    logic              bad;
    logic              last;
    logic              len_ok;
    logic              tstamp;
  } itv_item_t;

endpackage

`default_nettype wire

FILE: rtl/itv_front.sv
// front end: position tracking, layout and character class check
`timescale 1ns / 1ps
`default_nettype none

module itv_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_data,
  input  wire logic                     in_valid,
  input  wire logic [itv_pkg::CharW-1:0] in_char,
  input  wire logic                     in_last,
  input  wire logic                     q_full,
  output logic                          in_ready,
  output logic                          q_push,
  output itv_pkg::itv_item_t            q_item
);
  import itv_pkg::*;

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChT     = 8'h54;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChZ     = 8'h5A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChNone  = 8'h00;

  logic            fmt_r;
  logic [PosW-1:0] pos_r;
  logic [PosW-1:0] pos_nxt;
  logic [PosW-1:0] last_pos;
  logic [CharW-1:0] sep;
  logic            is_digit;
  logic            past_end;
  itv_field_t      field;

  function automatic logic [CharW-1:0] sep_at(input logic [PosW-1:0] p);
    case (p)
      5'd4, 5'd7:   sep_at = ChDash;
      5'd10:        sep_at = ChT;
      5'd13, 5'd16: sep_at = ChColon;
      5'd19:        sep_at = ChDot;
      5'd23:        sep_at = ChZ;
      default:      sep_at = ChNone;
    endcase
  endfunction

  function automatic itv_field_t field_at(input logic [PosW-1:0] p);
    case (p)
      5'd0, 5'd1:   field_at = FLD_YEAR_HI;
      5'd2, 5'd3:   field_at = FLD_YEAR_LO;
      5'd5, 5'd6:   field_at = FLD_MONTH;
      5'd8, 5'd9:   field_at = FLD_DAY;
      5'd11, 5'd12: field_at = FLD_HOUR;
      5'd14, 5'd15: field_at = FLD_MINUTE;
      5'd17, 5'd18: field_at = FLD_SECOND;
      default:      field_at = FLD_NONE;
    endcase
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    last_pos = fmt_r ? StampLastPos : DateLastPos;
    past_end = pos_r > last_pos;
    sep      = sep_at(pos_r);
    is_digit = (in_char >= ChZero) && (in_char <= ChNine);
    field    = field_at(pos_r);

    q_item        = '0;
    q_item.digit  = in_char[DigitW-1:0];
    q_item.last   = in_last;
    q_item.len_ok = (pos_r == last_pos);
    q_item.tstamp = fmt_r;
    q_item.field  = FLD_NONE;
    if (past_end) begin
      q_item.bad = 1'b1;
    end else if (sep != ChNone) begin
      q_item.bad = (in_char != sep);
    end else if (!is_digit) begin
      q_item.bad = 1'b1;
    end else begin
      // millisecond digits fall through as FLD_NONE: class check only
      q_item.field = field;
    end

    if (in_last) begin
      pos_nxt = '0;
    end else if (pos_r == PosMax) begin
      pos_nxt = PosMax;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
      pos_r <= '0;
    end else begin
      if (cfg_valid) begin
        fmt_r <= cfg_data;
      end
      if (q_push) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itv_fifo.sv
// small queue of classified characters between front end and checker
`timescale 1ns / 1ps
`default_nettype none

module itv_fifo #(
  parameter int Depth = itv_pkg::QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  itv_pkg::itv_item_t      push_item,
  output logic                    full,
  input  wire logic               pop,
  output itv_pkg::itv_item_t      pop_item,
  output logic                    not_empty
);
  import itv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  itv_item_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (cnt_r == CntFull);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itv_back.sv
// back end: field accumulation, range and calendar checks, result register
`timescale 1ns / 1ps
`default_nettype none

module itv_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  itv_pkg::itv_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  output logic               out_result,
  input  wire logic          out_ready
);
  import itv_pkg::*;

  localparam logic [FieldW-1:0] MonthMax  = 7'd12;
  localparam logic [FieldW-1:0] HourMax   = 7'd23;
  localparam logic [FieldW-1:0] MinSecMax = 7'd59;

  logic              broken_r, broken_nxt;
  logic [FieldW-1:0] yhi_r, yhi_nxt;
  logic [FieldW-1:0] ylo_r, ylo_nxt;
  logic [FieldW-1:0] month_r, month_nxt;
  logic [FieldW-1:0] day_r, day_nxt;
  logic [FieldW-1:0] hour_r, hour_nxt;
  logic [FieldW-1:0] min_r, min_nxt;
  logic [FieldW-1:0] sec_r, sec_nxt;
  logic              out_valid_r;
  logic              out_result_r;
  logic              leap;
  logic [FieldW-1:0] mdays;
  logic              ok;

  function automatic logic [FieldW-1:0] push_digit(input logic [FieldW-1:0] v,
                                                   input logic [DigitW-1:0] d);
    logic [FieldW+2:0] s;
    s = {v, 3'b000} + {2'b00, v, 1'b0} + {{(FieldW-1){1'b0}}, d};
    return s[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] month_days(input logic [FieldW-1:0] m,
                                                   input logic lp);
    case (m)
      7'd2:                      month_days = lp ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   month_days = 7'd30;
      default:                   month_days = 7'd31;
    endcase
  endfunction

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  // a last character waits only while an untaken result sits in the register
  assign q_pop = q_not_empty && (!q_item.last || !out_valid_r || out_ready);

  always_comb begin
    broken_nxt = broken_r | q_item.bad;
    yhi_nxt    = yhi_r;
    ylo_nxt    = ylo_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    case (q_item.field)
      FLD_YEAR_HI: yhi_nxt   = push_digit(yhi_r, q_item.digit);
      FLD_YEAR_LO: ylo_nxt   = push_digit(ylo_r, q_item.digit);
      FLD_MONTH:   month_nxt = push_digit(month_r, q_item.digit);
      FLD_DAY:     day_nxt   = push_digit(day_r, q_item.digit);
      FLD_HOUR:    hour_nxt  = push_digit(hour_r, q_item.digit);
      FLD_MINUTE:  min_nxt   = push_digit(min_r, q_item.digit);
      FLD_SECOND:  sec_nxt   = push_digit(sec_r, q_item.digit);
      default:     ;
    endcase

    // year = 100*hi + lo: divisible by 4 follows lo, by 400 follows hi when lo is zero
    leap  = (ylo_nxt != '0) ? (ylo_nxt[1:0] == 2'b00) : (yhi_nxt[1:0] == 2'b00);
    mdays = month_days(month_nxt, leap);

    ok = !broken_nxt && q_item.len_ok
         && ((yhi_nxt != '0) || (ylo_nxt != '0))
         && (month_nxt != '0) && (month_nxt <= MonthMax)
         && (day_nxt != '0) && (day_nxt <= mdays)
         && (!q_item.tstamp
             || ((hour_nxt <= HourMax) && (min_nxt <= MinSecMax)
                 && (sec_nxt <= MinSecMax)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      broken_r    <= 1'b0;
      yhi_r       <= '0;
      ylo_r       <= '0;
      month_r     <= '0;
      day_r       <= '0;
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_item.last) begin
        broken_r    <= 1'b0;
        yhi_r       <= '0;
        ylo_r       <= '0;
        month_r     <= '0;
        day_r       <= '0;
        hour_r      <= '0;
        min_r       <= '0;
        sec_r       <= '0;
        out_valid_r <= 1'b1;
      end else begin
        if (q_pop) begin
          broken_r <= broken_nxt;
          yhi_r    <= yhi_nxt;
          ylo_r    <= ylo_nxt;
          month_r  <= month_nxt;
          day_r    <= day_nxt;
          hour_r   <= hour_nxt;
          min_r    <= min_nxt;
          sec_r    <= sec_nxt;
        end
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_result_r <= ok;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iso_timestamp_validator_unit.sv
// top level of the iso date / timestamp string validator
`timescale 1ns / 1ps
`default_nettype none

// Checks a string, one character per transfer with tlast on the final one,
// against YYYY-MM-DD (cfg_data = 0) or YYYY-MM-DDTHH:MM:SS.mmmZ (cfg_data = 1),
// including digit classes, exact separators, exact length, nonzero year,
// month 1-12, day within the Gregorian month length, and hour/minute/second
// ranges in timestamp mode. Each tlast character produces one output transfer
// with out_tdata[0] = 1 for a valid string. The block takes one character per
// cycle while the queue has room; a character passes the front end (position
// and class check) into a small queue, and the back end pops it and folds it
// into the field registers; popping the last character loads the result
// register. A pending result only stalls the next last character, not the
// characters before it. The user must write the mode register (cfg_valid,
// cfg_data) only while no string is in flight; the block does not enforce it.

module iso_timestamp_validator_unit #(
  parameter int QueueDepth = itv_pkg::QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,   // timestamp_format
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_code
  input  wire logic       in_tlast,   // last_char
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] string_valid, [7:1] zero
);
  import itv_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  itv_item_t q_in_item;
  itv_item_t q_out_item;
  logic      result;

  assign cfg_ready = 1'b1;
  assign out_tdata = {7'b0000000, result};

  itv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  itv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .not_empty (q_not_empty)
  );

  itv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_out_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_result  (result),
    .out_ready   (out_tready)
  );

endmodule

`default_nettype wire
